/* src/lrdl_pkg.sv */
// Package with the shared types, codes and saturation and absolute-value helpers of the dense layer trainer.
`timescale 1ns / 1ps
package lrdl_pkg;

	localparam int IDX_W = 11;

	localparam logic [2:0] OP_LOAD_WEIGHT = 3'd0;
	localparam logic [2:0] OP_LOAD_BIAS   = 3'd1;
	localparam logic [2:0] OP_INPUT       = 3'd2;
	localparam logic [2:0] OP_ERROR       = 3'd3;
	localparam logic [2:0] OP_MAX_GRAD    = 3'd4;
	localparam logic [2:0] OP_UPDATE      = 3'd5;

	localparam logic [1:0] KIND_FWD = 2'd0;
	localparam logic [1:0] KIND_ERR = 2'd1;
	localparam logic [1:0] KIND_MAX = 2'd2;
	localparam logic [1:0] KIND_UPD = 2'd3;

	localparam logic [1:0] CFG_LEARNING_RATE = 2'd0;
	localparam logic [1:0] CFG_FIRST_INPUT   = 2'd1;
	localparam logic [1:0] CFG_INPUT_COUNT   = 2'd2;
	localparam logic [1:0] CFG_NEURON_COUNT  = 2'd3;

	localparam logic signed [47:0] LEAK_Q16 = 48'sd655;

	typedef struct packed {
		logic [2:0]         op;
		logic [5:0]         neuron;
		logic [7:0]         input_index;
		logic signed [15:0] value;
		logic               final_input;
		logic [30:0]        prior_max;
	} in_t;

	typedef struct packed {
		logic [5:0]         out_neuron;
		logic signed [31:0] out_value;
		logic               out_last;
	} out_t;

	typedef struct packed {
		logic               init;
		logic               go;
		logic               fin;
		logic               load;
		logic               shift;
		logic               clr;
		logic               ld_w;
		logic               ld_b;
		logic [1:0]         kind;
		logic [5:0]         neuron;
		logic [6:0]         nn;
		logic signed [15:0] value;
		logic [15:0]        lr;
	} ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
		if (x > 36'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (x < -36'sd2147483648) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [35:0] x);
		if (x > 36'sd32767) begin
			return 16'sh7fff;
		end else if (x < -36'sd32768) begin
			return 16'sh8000;
		end
		return x[15:0];
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] x);
		logic [31:0] r;
		r = x[31] ? (~x + 32'd1) : x;
		return r;
	endfunction

endpackage

/* src/lrdl_cell.sv */
// One neuron cell: weight and gradient rows, bias, output and a link of the result chain.
`timescale 1ns / 1ps
module lrdl_cell #(
	parameter int MAX_INPUTS = 256,
	parameter int IW = 8,
	parameter int CELL_ID = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lrdl_pkg::ctl_t      ctl,
	input  logic [IW-1:0]       addr,
	input  logic signed [15:0]  act,
	input  logic [31:0]         nxt,
	output logic [31:0]         sh
);

	logic signed [15:0] wmem [MAX_INPUTS];
	logic signed [31:0] gmem [MAX_INPUTS];

	logic en, sel;
	logic go_s1, go_s2;
	logic [IW-1:0] addr_s1, addr_s2;
	logic signed [15:0] w_rd;
	logic signed [31:0] g_rd;
	logic signed [33:0] term_s2;
	logic signed [31:0] g_s2;
	logic signed [15:0] w_s2;
	logic signed [31:0] acc_q, ek_q, out_q, bg_q;
	logic signed [15:0] b_q;
	logic [31:0] mx_q, sh_q;

	logic signed [31:0] v32, a32, w32, ek_new, prod_f, act_val;
	logic signed [47:0] ek48, a48, g48, lr48, prod_e, prod_u, acc48, leak48, bg48, bstep48;
	logic signed [33:0] term;

	assign sel = (ctl.neuron == 6'(CELL_ID));
	assign en = (ctl.kind == lrdl_pkg::KIND_ERR) ? sel : (7'(CELL_ID) < ctl.nn);
	assign sh = sh_q;

	always_comb begin
		v32 = 32'(ctl.value);
		ek_new = (out_q < 0) ? (v32 * 32'sd655) : (v32 <<< 16);
		a32 = 32'(act);
		w32 = 32'(w_rd);
		prod_f = a32 * w32;
		ek48 = 48'(ek_q);
		a48 = 48'(act);
		prod_e = ek48 * a48;
		g48 = 48'(g_rd);
		lr48 = $signed({32'd0, ctl.lr});
		prod_u = g48 * lr48;
		case (ctl.kind)
			lrdl_pkg::KIND_FWD: term = 34'(prod_f);
			lrdl_pkg::KIND_ERR: term = 34'(prod_e >>> 16);
			lrdl_pkg::KIND_UPD: term = 34'(prod_u >>> 28);
			default:            term = '0;
		endcase
		acc48 = 48'(acc_q);
		leak48 = acc48 * lrdl_pkg::LEAK_Q16;
		act_val = (acc_q > 0) ? acc_q : 32'(leak48 >>> 16);
		bg48 = 48'(bg_q);
		bstep48 = (bg48 * lr48) >>> 28;
	end

	always_ff @(posedge clk) begin
		w_rd <= wmem[addr];
		g_rd <= gmem[addr];
		if (ctl.clr) begin
			gmem[addr] <= '0;
		end else if (go_s2 && ctl.kind == lrdl_pkg::KIND_ERR) begin
			gmem[addr_s2] <= lrdl_pkg::sat32(36'(g_s2) + 36'(term_s2));
		end else if (go_s2 && ctl.kind == lrdl_pkg::KIND_UPD) begin
			gmem[addr_s2] <= '0;
		end
		if (ctl.ld_w && sel) begin
			wmem[addr] <= ctl.value;
		end else if (go_s2 && ctl.kind == lrdl_pkg::KIND_UPD) begin
			wmem[addr_s2] <= lrdl_pkg::sat16(36'(w_s2) + 36'(term_s2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			go_s2 <= 1'b0;
			out_q <= '0;
			bg_q <= '0;
		end else begin
			go_s1 <= ctl.go && en;
			go_s2 <= go_s1;
			if (ctl.fin && en) begin
				case (ctl.kind)
					lrdl_pkg::KIND_FWD: out_q <= act_val;
					lrdl_pkg::KIND_ERR: bg_q <= lrdl_pkg::sat32(36'(bg_q) + 36'(ek_q >>> 4));
					lrdl_pkg::KIND_UPD: bg_q <= '0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		addr_s2 <= addr_s1;
		term_s2 <= term;
		g_s2 <= g_rd;
		w_s2 <= w_rd;
		if (ctl.init) begin
			acc_q <= {{4{b_q[15]}}, b_q, 12'd0};
			ek_q <= ek_new;
			mx_q <= '0;
		end else if (go_s2 && ctl.kind == lrdl_pkg::KIND_FWD) begin
			acc_q <= lrdl_pkg::sat32(36'(acc_q) + 36'(term_s2));
		end else if (go_s2 && ctl.kind == lrdl_pkg::KIND_MAX) begin
			if (lrdl_pkg::abs32(g_s2) > mx_q) begin
				mx_q <= lrdl_pkg::abs32(g_s2);
			end
		end else if (ctl.fin && en && ctl.kind == lrdl_pkg::KIND_MAX) begin
			if (lrdl_pkg::abs32(bg_q) > mx_q) begin
				mx_q <= lrdl_pkg::abs32(bg_q);
			end
		end
		if (ctl.ld_b && sel) begin
			b_q <= ctl.value;
		end else if (ctl.fin && en && ctl.kind == lrdl_pkg::KIND_UPD) begin
			b_q <= lrdl_pkg::sat16(36'(b_q) + 36'(bstep48));
		end
		if (ctl.load) begin
			if (ctl.kind == lrdl_pkg::KIND_FWD) begin
				sh_q <= out_q;
			end else begin
				sh_q <= en ? mx_q : 32'd0;
			end
		end else if (ctl.shift) begin
			if (ctl.kind == lrdl_pkg::KIND_MAX) begin
				sh_q <= (nxt > sh_q) ? nxt : sh_q;
			end else begin
				sh_q <= nxt;
			end
		end
	end

endmodule

/* src/leaky_relu_dense_layer_trainer.sv */
// Top level of the leaky ReLU dense layer trainer: sequencer, input store and cell chain.
//
// Items arrive on item_valid/item_stall and results leave on result_valid/result_stall;
// a transfer happens at a clock edge with valid high and stall low. Configuration is
// written through cfg_we, cfg_index and cfg_data; the user must do so only while the block is
// idle, which the block itself does not enforce. Loads of weights, biases and non-final
// inputs leave the block idle. Error items for a neuron in use, max and update items and
// final inputs walk the inputs in use, one position per cycle, in every cell in use at once
// (an error item only in its own neuron cell). The forward pass then loads the result
// chain and reports the neurons in use; the max operation loads the chain, reduces it
// along the chain and outputs one result. Forward results are shifted out of the cell
// chain, neuron 0 first, the last one flagged by out_last. The result register lets the
// next item be taken while a result waits. When the receiver stalls, the output chain
// holds until the result is taken.
// After reset the gradient rows are cleared, one address a cycle in all cells, over all
// MAX_INPUTS addresses; items are stalled during that pass, configuration writes are not.
`timescale 1ns / 1ps
module leaky_relu_dense_layer_trainer #(
	parameter int MAX_NEURONS = 16,
	parameter int MAX_INPUTS = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  lrdl_pkg::in_t   item,
	output logic            result_valid,
	input  logic            result_stall,
	output lrdl_pkg::out_t  result,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data
);

	localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_INIT   = 4'd2;
	localparam logic [3:0] S_WALK   = 4'd3;
	localparam logic [3:0] S_DRAIN  = 4'd4;
	localparam logic [3:0] S_FIN    = 4'd5;
	localparam logic [3:0] S_LOAD   = 4'd6;
	localparam logic [3:0] S_OUT    = 4'd7;
	localparam logic [3:0] S_REDUCE = 4'd8;
	localparam logic [3:0] S_MAXOUT = 4'd9;

	logic [3:0] state_q;
	logic [1:0] kind_q;
	logic signed [15:0] val_q;
	logic [5:0] nrn_q;
	logic [30:0] prior_q;
	logic [lrdl_pkg::IDX_W-1:0] idx_q, ie, addr_full;
	logic [6:0] cnt_q, nn;
	logic [15:0] lr_q;
	logic [8:0] first_q, count_q;
	logic [6:0] ncount_q;

	logic signed [15:0] amem [MAX_INPUTS];
	logic signed [15:0] act_rd;
	logic [IW-1:0] addr;
	logic acc_in, out_free, last_out;
	logic [31:0] max_m, max_sat;
	lrdl_pkg::ctl_t ctl;
	lrdl_pkg::out_t res_q;
	logic res_valid_q;
	logic [31:0] chain [MAX_NEURONS+1];

	assign nn = (ncount_q < 7'(MAX_NEURONS)) ? ncount_q : 7'(MAX_NEURONS);
	assign ie = (11'(count_q) < 11'(MAX_INPUTS)) ? 11'(count_q) : 11'(MAX_INPUTS);
	assign item_stall = (state_q != S_IDLE);
	assign acc_in = item_valid && !item_stall;
	assign out_free = !res_valid_q || !result_stall;
	assign last_out = (cnt_q == nn - 7'd1);
	assign addr_full = (state_q == S_IDLE) ? 11'(item.input_index) : idx_q;
	assign addr = addr_full[IW-1:0];
	assign max_m = (chain[0] > {1'b0, prior_q}) ? chain[0] : {1'b0, prior_q};
	assign max_sat = max_m[31] ? 32'h7fffffff : max_m;
	assign result_valid = res_valid_q;
	assign result = res_q;
	assign chain[MAX_NEURONS] = 32'd0;

	always_comb begin
		ctl.init = (state_q == S_INIT);
		ctl.go = (state_q == S_WALK) && (idx_q < ie);
		ctl.fin = (state_q == S_FIN);
		ctl.load = (state_q == S_LOAD);
		ctl.shift = ((state_q == S_OUT) && out_free) || (state_q == S_REDUCE);
		ctl.clr = (state_q == S_CLEAR);
		ctl.ld_w = acc_in && (item.op == lrdl_pkg::OP_LOAD_WEIGHT) &&
			(11'(item.input_index) < 11'(MAX_INPUTS));
		ctl.ld_b = acc_in && (item.op == lrdl_pkg::OP_LOAD_BIAS);
		ctl.kind = kind_q;
		ctl.neuron = (state_q == S_IDLE) ? item.neuron : nrn_q;
		ctl.nn = nn;
		ctl.value = (state_q == S_IDLE) ? item.value : val_q;
		ctl.lr = lr_q;
	end

	always_ff @(posedge clk) begin
		act_rd <= amem[addr];
		if (acc_in && item.op == lrdl_pkg::OP_INPUT && 11'(item.input_index) < 11'(MAX_INPUTS)) begin
			amem[addr] <= item.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= 16'd655;
			first_q <= 9'd0;
			count_q <= 9'd256;
			ncount_q <= 7'd16;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrdl_pkg::CFG_LEARNING_RATE: lr_q <= cfg_data;
				lrdl_pkg::CFG_FIRST_INPUT:   first_q <= cfg_data[8:0];
				lrdl_pkg::CFG_INPUT_COUNT:   count_q <= cfg_data[8:0];
				lrdl_pkg::CFG_NEURON_COUNT:  ncount_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			val_q <= item.value;
			nrn_q <= item.neuron;
			prior_q <= item.prior_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			kind_q <= lrdl_pkg::KIND_FWD;
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 11'd1;
					if (idx_q == 11'(MAX_INPUTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc_in) begin
						case (item.op)
							lrdl_pkg::OP_INPUT: begin
								if (item.final_input) begin
									kind_q <= lrdl_pkg::KIND_FWD;
									state_q <= S_INIT;
								end
							end
							lrdl_pkg::OP_ERROR: begin
								if (7'(item.neuron) < nn) begin
									kind_q <= lrdl_pkg::KIND_ERR;
									state_q <= S_INIT;
								end
							end
							lrdl_pkg::OP_MAX_GRAD: begin
								kind_q <= lrdl_pkg::KIND_MAX;
								state_q <= S_INIT;
							end
							lrdl_pkg::OP_UPDATE: begin
								kind_q <= lrdl_pkg::KIND_UPD;
								state_q <= S_INIT;
							end
							default: ;
						endcase
					end
				end
				S_INIT: begin
					idx_q <= 11'(first_q);
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (idx_q < ie) begin
						idx_q <= idx_q + 11'd1;
					end else begin
						cnt_q <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd2) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (kind_q == lrdl_pkg::KIND_ERR || kind_q == lrdl_pkg::KIND_UPD) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					cnt_q <= '0;
					if (kind_q == lrdl_pkg::KIND_FWD) begin
						state_q <= (nn == 7'd0) ? S_IDLE : S_OUT;
					end else begin
						state_q <= (MAX_NEURONS == 1) ? S_MAXOUT : S_REDUCE;
					end
				end
				S_OUT: begin
					if (out_free) begin
						cnt_q <= cnt_q + 7'd1;
						if (last_out) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_REDUCE: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(MAX_NEURONS - 2)) begin
						state_q <= S_MAXOUT;
					end
				end
				S_MAXOUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_OUT || state_q == S_MAXOUT) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			res_q.out_neuron <= cnt_q[5:0];
			res_q.out_value <= chain[0];
			res_q.out_last <= last_out;
		end else if (state_q == S_MAXOUT && out_free) begin
			res_q.out_neuron <= 6'd0;
			res_q.out_value <= max_sat;
			res_q.out_last <= 1'b1;
		end
	end

	for (genvar g = 0; g < MAX_NEURONS; g++) begin : g_cell
		lrdl_cell #(
			.MAX_INPUTS(MAX_INPUTS),
			.IW(IW),
			.CELL_ID(g)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.addr(addr),
			.act(act_rd),
			.nxt(chain[g+1]),
			.sh(chain[g])
		);
	end

endmodule

/* src/lrdl_check.sv */
// Port-level checker for the dense layer trainer and its bind to the top level.
`timescale 1ns / 1ps
module lrdl_check (
	input logic            clk,
	input logic            arst_n,
	input logic            item_valid,
	input logic            item_stall,
	input lrdl_pkg::in_t   item,
	input logic            result_valid,
	input logic            result_stall,
	input lrdl_pkg::out_t  result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_update_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op == lrdl_pkg::OP_UPDATE |=> item_stall)
		else $error("update transfer did not start a walk");

	a_max_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op == lrdl_pkg::OP_MAX_GRAD |=> item_stall)
		else $error("max transfer did not start a walk");

	a_fwd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op == lrdl_pkg::OP_INPUT && item.final_input
		|=> item_stall)
		else $error("final input transfer did not start the forward pass");

endmodule

bind leaky_relu_dense_layer_trainer lrdl_check u_lrdl_check (.*);
